FILE: rtl/assert_macros.svh
// Assertion macros shared by the oscillator bank RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clock edge, silent while reset is held.
`define AOB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check, also active during reset.
`define AOB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/aob_pkg.sv
`timescale 1ns / 1ps
// Package of the additive oscillator bank: sizes, codes and fixed-point constants.
// No dependencies; used by the top level.
package aob_pkg;

  localparam int MAX_PARTIALS = 64;
  localparam int MAX_BINS     = 64;
  localparam int IDX_W        = $clog2(MAX_PARTIALS);
  localparam int CNT_W        = 7;

  typedef enum logic [1:0] {
    ACT_LOAD_STEP = 2'd0,
    ACT_LOAD_ENV  = 2'd1,
    ACT_TICK      = 2'd2,
    ACT_RESTART   = 2'd3
  } action_e;

  typedef enum logic {
    REG_PARTIAL_COUNT = 1'b0,
    REG_ENVELOPE_BINS = 1'b1
  } reg_idx_e;

  // exp(): log2(e) in Q16, and the bias that keeps y non-negative
  localparam logic [16:0] LOG2E_Q16  = 17'd94548;
  localparam logic [33:0] EXP_OFFSET = 34'd123076608;
  localparam logic [6:0]  EXP_K_BIAS = 7'd24;
  localparam logic [16:0] EXP_C3     = 17'd4366;
  localparam logic [16:0] EXP_C2     = 17'd15744;
  localparam logic [16:0] EXP_C1     = 17'd45426;
  localparam logic [16:0] ONE_Q16    = 17'd65536;

  // sine polynomial
  localparam logic [16:0] SIN_C3 = 17'd4926;
  localparam logic [16:0] SIN_C2 = 17'd42334;
  localparam logic [16:0] SIN_C1 = 17'd102944;

  localparam logic [16:0] GAIN_HARM  = 17'd6554;
  localparam logic [16:0] GAIN_NOISE = 17'd1311;

  localparam logic [5:0] DIV_TOP_BIT = 6'd36;

endpackage

FILE: rtl/aob_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the oscillator bank: command in, sample out.
// Depends on nothing but the widths of the fields.
interface aob_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  slot;
  logic [31:0] phase_step;
  logic signed [15:0] log_amplitude;

  modport source (output valid, action, slot, phase_step, log_amplitude, input ready);
  modport sink   (input valid, action, slot, phase_step, log_amplitude, output ready);
endinterface

interface aob_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

FILE: rtl/additive_oscillator_bank.sv
`timescale 1ns / 1ps
// Additive oscillator bank: harmonic partials plus one sine per envelope bin.
// Depends on aob_pkg, aob_if.sv and assert_macros.svh.
//
//   channel   dir  handshake      payload
//   in_ch_i   in   valid/ready    action, slot, phase_step, log_amplitude
//   out_ch_o  out  valid/ready    sample (one per tick)
//   APB       in   psel/penable   partial_count @0x0, envelope_bins @0x4
//
// A tick sums the P partials and then the B envelope bins in use, and goes
// straight to the output if either count is zero; each oscillator is a chain of
// multiplies through the one shared 32x17 multiplier. A restart computes a step
// per bin, one quotient bit per cycle from the restoring divider.
// Reset clears counts, phase valid bits and control; table contents stay undefined.
// in_ch_i.ready is high only while idle; a finished sample waits in the output
// register, and the next command is taken while it is still pending.
module additive_oscillator_bank import aob_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  aob_in_if.sink      in_ch_i,
  aob_out_if.source   out_ch_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "assert_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV,
    ST_H0, ST_H1, ST_H2, ST_H3,
    ST_N0, ST_N1,
    ST_E1, ST_E2, ST_E3, ST_E4,
    ST_S1, ST_S2, ST_S3, ST_S4,
    ST_T1, ST_T2, ST_T3,
    ST_DONE
  } state_e;

  // ---------------------------------------------------------------- config
  logic [CNT_W-1:0] partial_count_q, envelope_bins_q;
  logic [CNT_W-1:0] np_eff, nb_eff;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_PARTIAL_COUNT: prdata = {25'd0, partial_count_q};
      REG_ENVELOPE_BINS: prdata = {25'd0, envelope_bins_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_count_q <= '0;
      envelope_bins_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        REG_PARTIAL_COUNT: partial_count_q <= pwdata[CNT_W-1:0];
        REG_ENVELOPE_BINS: envelope_bins_q <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign np_eff = (partial_count_q > CNT_W'(MAX_PARTIALS)) ? CNT_W'(MAX_PARTIALS)
                                                           : partial_count_q;
  assign nb_eff = (envelope_bins_q > CNT_W'(MAX_BINS)) ? CNT_W'(MAX_BINS)
                                                       : envelope_bins_q;

  // ---------------------------------------------------------------- state
  state_e            state_q;
  logic [IDX_W-1:0]  idx_q;
  logic              harm_q;
  logic [5:0]        div_bit_q;
  logic [6:0]        div_rem_q;
  logic [31:0]       div_quo_q;
  logic signed [47:0] sum_q;
  logic              out_valid_q;
  logic signed [31:0] sample_q;
  logic [MAX_PARTIALS-1:0] pvld_q;
  logic [MAX_BINS-1:0]     bvld_q;

  // datapath registers
  logic [48:0] p_q;
  logic [31:0] cur_step_q, cur_phase_q;
  logic [6:0]  kraw_q;
  logic [15:0] g_q;
  logic [16:0] amp_q, z2_q, lo_q;
  logic [40:0] x_q;

  // memories and their read registers
  logic [31:0] pstep_mem [MAX_PARTIALS];
  logic [31:0] pph_mem   [MAX_PARTIALS];
  logic [15:0] env_mem   [MAX_BINS];
  logic [31:0] bph_mem   [MAX_BINS];
  logic [31:0] bstep_mem [MAX_BINS];
  logic [31:0] pstep_rd_q, pph_rd_q, bph_rd_q, bstep_rd_q;
  logic [15:0] env_rd_q;
  logic        pph_ok_q, bph_ok_q;

  logic in_acc;
  assign in_ch_i.ready = (state_q == ST_IDLE);
  assign in_acc        = in_ch_i.valid & in_ch_i.ready;
  assign out_ch_o.valid  = out_valid_q;
  assign out_ch_o.sample = sample_q;

  // ---------------------------------------------------------------- datapath
  logic [16:0] p_hi, z, f17;
  logic [7:0]  bin_raw;
  logic [IDX_W-1:0] bin_idx, env_addr;
  logic [33:0] y;
  logic        kge;
  logic [4:0]  ls_amt, rs_amt;
  logic [16:0] m, amp_d;
  logic [56:0] shl;
  logic [40:0] x_d;
  logic [39:0] mag;
  logic signed [47:0] sum_d;
  logic [16:0] gain;
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [6:0]  odd;
  logic [36:0] dvd;
  logic [7:0]  rem_sh;
  logic        div_ge;
  logic [6:0]  rem_d;
  logic [31:0] quo_d;
  logic [IDX_W:0] idx_nxt;

  assign p_hi = p_q[32:16];
  assign f17  = {1'b0, cur_phase_q[29:14]};
  assign z    = cur_phase_q[30] ? (ONE_Q16 - f17) : f17;

  // envelope bin of a partial, clamped to the last bin
  assign bin_raw = p_q[38:31];
  assign bin_idx = (bin_raw >= {1'b0, nb_eff}) ? IDX_W'(nb_eff - 7'd1) : bin_raw[IDX_W-1:0];
  assign env_addr = (state_q == ST_H2) ? bin_idx : idx_q;

  // exp: y = L*log2e + bias, integer part in y[33:27], fraction in y[26:11]
  assign y      = p_q[33:0] + EXP_OFFSET;
  assign kge    = (kraw_q >= EXP_K_BIAS);
  assign ls_amt = 5'(kraw_q - EXP_K_BIAS);
  assign rs_amt = 5'(EXP_K_BIAS - kraw_q);
  assign m      = ONE_Q16 + p_hi;
  assign amp_d  = kge ? m : (m >> rs_amt);

  // a left exponent is applied after the amp*sine product (exact for truncation)
  assign shl = {23'd0, p_q[33:0]} << ls_amt;
  assign x_d = kge ? shl[56:16] : {7'd0, p_q[33:16]};
  assign mag = {p_q[35:0], 4'd0} + {23'd0, lo_q};
  assign sum_d = cur_phase_q[31] ? (sum_q - $signed({8'd0, mag}))
                                 : (sum_q + $signed({8'd0, mag}));
  assign gain = harm_q ? GAIN_HARM : GAIN_NOISE;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_H1: begin mul_a = pstep_rd_q; mul_b = {10'd0, nb_eff}; end
      ST_H3, ST_N1: begin mul_a = {16'd0, env_rd_q ^ 16'h8000}; mul_b = LOG2E_Q16; end
      ST_E1: begin mul_a = {16'd0, y[26:11]}; mul_b = EXP_C3; end
      ST_E2: begin mul_a = {16'd0, g_q}; mul_b = EXP_C2 + p_hi; end
      ST_E3: begin mul_a = {16'd0, g_q}; mul_b = EXP_C1 + p_hi; end
      ST_E4: begin mul_a = {15'd0, z}; mul_b = z; end
      ST_S1: begin mul_a = {15'd0, p_hi}; mul_b = SIN_C3; end
      ST_S2: begin mul_a = {15'd0, z2_q}; mul_b = SIN_C2 - p_hi; end
      ST_S3: begin mul_a = {15'd0, z}; mul_b = SIN_C1 - p_hi; end
      ST_S4: begin mul_a = {15'd0, amp_q}; mul_b = p_hi; end
      ST_T1: begin mul_a = {12'd0, x_d[19:0]}; mul_b = gain; end
      ST_T2: begin mul_a = {11'd0, x_q[40:20]}; mul_b = gain; end
      default: ;
    endcase
  end

  // restoring divider: ((2i+1) << 30) / B, one quotient bit a cycle
  assign odd    = {idx_q, 1'b1};
  assign dvd    = {odd, 30'd0};
  assign rem_sh = {div_rem_q, dvd[div_bit_q]};
  assign div_ge = (rem_sh >= {1'b0, nb_eff});
  assign rem_d  = div_ge ? 7'(rem_sh - {1'b0, nb_eff}) : rem_sh[6:0];
  assign quo_d  = {div_quo_q[30:0], div_ge};
  assign idx_nxt = {1'b0, idx_q} + 7'd1;

  always_ff @(posedge clk_i) begin
    p_q <= 49'(mul_a) * 49'(mul_b);
    case (state_q)
      ST_H1: begin
        cur_step_q  <= pstep_rd_q;
        cur_phase_q <= pph_ok_q ? pph_rd_q : '0;
      end
      ST_N1: begin
        cur_step_q  <= bstep_rd_q;
        cur_phase_q <= bph_ok_q ? bph_rd_q : '0;
      end
      ST_E1: begin
        kraw_q <= y[33:27];
        g_q    <= y[26:11];
      end
      ST_E4: amp_q <= amp_d;
      ST_S1: z2_q  <= p_hi;
      ST_T1: x_q   <= x_d;
      ST_T2: lo_q  <= p_hi;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (in_acc && in_ch_i.action == ACT_LOAD_STEP) pstep_mem[in_ch_i.slot] <= in_ch_i.phase_step;
    if (in_acc && in_ch_i.action == ACT_LOAD_ENV)  env_mem[in_ch_i.slot] <= in_ch_i.log_amplitude;
    if (state_q == ST_DIV && div_bit_q == '0)       bstep_mem[idx_q] <= quo_d;
    if (state_q == ST_T3 && harm_q)                 pph_mem[idx_q] <= cur_phase_q + cur_step_q;
    if (state_q == ST_T3 && !harm_q)                bph_mem[idx_q] <= cur_phase_q + cur_step_q;
    pstep_rd_q <= pstep_mem[idx_q];
    pph_rd_q   <= pph_mem[idx_q];
    bph_rd_q   <= bph_mem[idx_q];
    bstep_rd_q <= bstep_mem[idx_q];
    env_rd_q   <= env_mem[env_addr];
    pph_ok_q   <= pvld_q[idx_q];
    bph_ok_q   <= bvld_q[idx_q];
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      harm_q      <= 1'b0;
      div_bit_q   <= '0;
      div_rem_q   <= '0;
      div_quo_q   <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
      pvld_q      <= '0;
      bvld_q      <= '0;
    end else begin
      // in ST_DONE a taken sample is replaced by the new one below
      if (out_valid_q && out_ch_o.ready && state_q != ST_DONE) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (action_e'(in_ch_i.action))
              ACT_RESTART: begin
                pvld_q    <= '0;
                bvld_q    <= '0;
                idx_q     <= '0;
                div_bit_q <= DIV_TOP_BIT;
                div_rem_q <= '0;
                if (nb_eff != '0) state_q <= ST_DIV;
              end
              ACT_TICK: begin
                sum_q  <= '0;
                idx_q  <= '0;
                harm_q <= 1'b1;
                state_q <= (np_eff == '0 || nb_eff == '0) ? ST_DONE : ST_H0;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          div_quo_q <= quo_d;
          if (div_bit_q == '0) begin
            div_bit_q <= DIV_TOP_BIT;
            div_rem_q <= '0;
            if (idx_nxt < {1'b0, nb_eff}) idx_q <= idx_nxt[IDX_W-1:0];
            else state_q <= ST_IDLE;
          end else begin
            div_rem_q <= rem_d;
            div_bit_q <= div_bit_q - 6'd1;
          end
        end
        ST_H0: state_q <= ST_H1;
        ST_H1: state_q <= ST_H2;
        ST_H2: state_q <= ST_H3;
        ST_H3: state_q <= ST_E1;
        ST_N0: state_q <= ST_N1;
        ST_N1: state_q <= ST_E1;
        ST_E1: state_q <= ST_E2;
        ST_E2: state_q <= ST_E3;
        ST_E3: state_q <= ST_E4;
        ST_E4: state_q <= ST_S1;
        ST_S1: state_q <= ST_S2;
        ST_S2: state_q <= ST_S3;
        ST_S3: state_q <= ST_S4;
        ST_S4: state_q <= ST_T1;
        ST_T1: state_q <= ST_T2;
        ST_T2: state_q <= ST_T3;
        ST_T3: begin
          sum_q <= sum_d;
          if (harm_q) begin
            pvld_q[idx_q] <= 1'b1;
            if (idx_nxt < {1'b0, np_eff}) begin
              idx_q   <= idx_nxt[IDX_W-1:0];
              state_q <= ST_H0;
            end else begin
              idx_q   <= '0;
              harm_q  <= 1'b0;
              state_q <= ST_N0;
            end
          end else begin
            bvld_q[idx_q] <= 1'b1;
            if (idx_nxt < {1'b0, nb_eff}) begin
              idx_q   <= idx_nxt[IDX_W-1:0];
              state_q <= ST_N0;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // wait for the output register to be free
          if (!out_valid_q || out_ch_o.ready) begin
            out_valid_q <= 1'b1;
            if (sum_q > 48'sh0000_7FFF_FFFF)       sample_q <= 32'sh7FFF_FFFF;
            else if (sum_q < -48'sh0000_8000_0000) sample_q <= 32'sh8000_0000;
            else                                   sample_q <= sum_q[31:0];
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- checks
  `AOB_ASSERT(a_div_rem_below_divisor, (state_q == ST_DIV) |-> (div_rem_q < nb_eff), "divider remainder not below divisor")
  `AOB_ASSERT(a_bin_in_range, (state_q == ST_H2) |-> (7'(bin_idx) < nb_eff), "envelope bin out of range")
  `AOB_ASSERT(a_done_holds, (state_q == ST_DONE && out_valid_q && !out_ch_o.ready) |=> (state_q == ST_DONE), "sample overwrote a pending result")

endmodule
